@@ rtl/bga_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bga_pkg
// Shared widths, register indexes, charge codes and discharge curve for the
// battery gauge averager.
// ----------------------------------------------------------------------------
package bga_pkg;

	localparam int RAW_W  = 12;
	localparam int MV_W   = 14;
	localparam int PCT_W  = 7;
	localparam int THR_W  = 7;
	localparam int ST_W   = 2;
	localparam int LVL_W  = 3;
	localparam int PROD_W = RAW_W + MV_W;
	localparam int REM_W  = 14;

	localparam int SAMPLES_PER_READING = 8;
	localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam int SUM_W = RAW_W + $clog2(SAMPLES_PER_READING);

	// ADC full-scale code, divisor of the millivolt conversion
	localparam int ADC_MAX = 4095;

	// config register indexes
	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_FULL_SCALE = 1'b0;
	localparam logic [IDX_W-1:0] REG_FULL_THR   = 1'b1;
	localparam logic [MV_W-1:0]  FULL_SCALE_RST = 14'd7800;
	localparam logic [THR_W-1:0] FULL_THR_RST   = 7'd99;

	// charge state codes
	localparam logic [ST_W-1:0] CS_DISCHARGING = 2'd0;
	localparam logic [ST_W-1:0] CS_CHARGING    = 2'd1;
	localparam logic [ST_W-1:0] CS_FULL        = 2'd2;

	// gauge icon levels
	localparam logic [LVL_W-1:0] LVL_CHARGING = 3'd0;
	localparam logic [LVL_W-1:0] LVL_LOW      = 3'd1;
	localparam logic [LVL_W-1:0] LVL_MID      = 3'd2;
	localparam logic [LVL_W-1:0] LVL_HIGH     = 3'd3;
	localparam logic [LVL_W-1:0] LVL_FULL     = 3'd4;
	localparam logic [PCT_W-1:0] PCT_LOW_LIM  = 7'd20;
	localparam logic [PCT_W-1:0] PCT_MID_LIM  = 7'd50;
	localparam logic [PCT_W-1:0] PCT_HIGH_LIM = 7'd80;

	// discharge curve, highest point first; every segment spans PCT_STEP
	localparam int CURVE_POINTS = 21;
	localparam int SEG_W        = $clog2(CURVE_POINTS);
	localparam int PCT_STEP     = 5;
	localparam int DIFF_W       = 8;
	localparam int DIFF5_W      = 10;
	localparam int OFF_W        = 3;

	localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
		14'd4200, 14'd4150, 14'd4100, 14'd4050, 14'd4000, 14'd3950, 14'd3900,
		14'd3850, 14'd3800, 14'd3750, 14'd3700, 14'd3650, 14'd3600, 14'd3550,
		14'd3500, 14'd3450, 14'd3400, 14'd3350, 14'd3300, 14'd3200, 14'd3000
	};
	localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
		7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
		7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
		7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
	};
	localparam logic [MV_W-1:0]  MV_TOP  = 14'd4200;
	localparam logic [MV_W-1:0]  MV_BOT  = 14'd3000;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	// averaged block handed from front to back
	typedef struct packed {
		logic [RAW_W-1:0] avg;
		logic             pin;
	} bga_reading_t;

	typedef struct packed {
		logic full;
		logic empty;
	} bga_qstat_t;

	typedef struct packed {
		logic [MV_W-1:0]  full_scale_mv;
		logic [THR_W-1:0] full_pct_threshold;
	} bga_cfg_t;

	typedef struct packed {
		logic [LVL_W-1:0] gauge_level;
		logic [ST_W-1:0]  charge_state;
		logic [PCT_W-1:0] charge_pct;
		logic [MV_W-1:0]  battery_mv;
	} bga_result_t;

endpackage
`default_nettype wire

@@ rtl/bga_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bga_front
// Sums samples over a block and pushes the block average with the last
// charger pin level.
// ----------------------------------------------------------------------------
module bga_front (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       take,
	input  wire [bga_pkg::RAW_W-1:0]  raw_sample,
	input  wire                       charger_pin,
	output logic                      push,
	output bga_pkg::bga_reading_t     push_data
);

	logic [bga_pkg::SUM_W-1:0] sum_q;
	logic [bga_pkg::CNT_W-1:0] count_q;
	logic [bga_pkg::SUM_W-1:0] sum_next;
	logic                      last;

	assign sum_next = sum_q + bga_pkg::SUM_W'(raw_sample);
	assign last     = (count_q == bga_pkg::CNT_W'(bga_pkg::SAMPLES_PER_READING - 1));
	assign push     = take && last;

	always_comb begin
		push_data.avg = bga_pkg::RAW_W'(sum_next / bga_pkg::SAMPLES_PER_READING);
		push_data.pin = charger_pin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (take) begin
			if (last) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bga_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bga_fifo
// Two-entry queue of block readings between front and back.
// ----------------------------------------------------------------------------
module bga_fifo (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	input  wire bga_pkg::bga_reading_t push_data,
	input  wire                        pop,
	output bga_pkg::bga_reading_t      pop_data,
	output bga_pkg::bga_qstat_t        stat
);

	bga_pkg::bga_reading_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign stat.full  = (fill_q == 2'd2);
	assign stat.empty = (fill_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)      fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/bga_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bga_back
// Pipeline from block average to millivolts, percent, charge state and
// gauge level, ending in the output register.
// ----------------------------------------------------------------------------
module bga_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire bga_pkg::bga_cfg_t     cfg,
	input  wire                        in_valid,
	input  wire bga_pkg::bga_reading_t in_data,
	output logic                       in_pop,
	output logic                       out_valid,
	output bga_pkg::bga_result_t       out_data,
	input  wire                        out_ready
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_q;

	logic [bga_pkg::PROD_W-1:0] prod_s1, prod_s2;
	logic [bga_pkg::MV_W-1:0]   est_s2, est_s3;
	logic [bga_pkg::REM_W-1:0]  rem_s3;
	logic [bga_pkg::MV_W-1:0]   mv_s4, mv_s5, mv_s6;
	logic [bga_pkg::SEG_W-1:0]  seg_s5;
	logic                       top_s5, bot_s5;
	logic [bga_pkg::PCT_W-1:0]  pct_s6;
	logic pin_s1, pin_s2, pin_s3, pin_s4, pin_s5, pin_s6;
	bga_pkg::bga_result_t res_q;

	logic [bga_pkg::PROD_W-1:0] est_sum;
	logic [bga_pkg::PROD_W-1:0] rem_full;
	logic [bga_pkg::MV_W-1:0]   mv_c;
	logic [bga_pkg::SEG_W-1:0]  seg_c;
	logic [bga_pkg::PCT_W-1:0]  pct_c;
	logic [bga_pkg::MV_W-1:0]   lo_mv, width_mv;
	logic [bga_pkg::DIFF_W-1:0] diff, width;
	logic [bga_pkg::DIFF5_W-1:0] diff5;
	logic [bga_pkg::OFF_W-1:0]  off;
	logic [bga_pkg::ST_W-1:0]   state_c;
	logic [bga_pkg::LVL_W-1:0]  level_c;

	function automatic logic [bga_pkg::PROD_W-1:0] prod_s3_term(
		input logic [bga_pkg::PROD_W-1:0] p,
		input logic [bga_pkg::MV_W-1:0]   q
	);
		logic [bga_pkg::PROD_W-1:0] qx;
		qx = bga_pkg::PROD_W'(q);
		return p - (qx << 12) + qx;
	endfunction

	// whole pipeline moves together; a stalled output freezes every stage
	assign adv       = !v_q || out_ready;
	assign in_pop    = adv;
	assign out_valid = v_q;
	assign out_data  = res_q;

	// floor(p / 4095): estimate from the series p/4096 + p/4096^2 + p/4096^3,
	// which falls short by at most two; the remainder corrects it
	assign est_sum  = prod_s1 + (prod_s1 >> 12) + (prod_s1 >> 24);
	assign rem_full = prod_s3_term(prod_s2, est_s2);

	always_comb begin
		if (rem_s3 >= bga_pkg::REM_W'(2 * bga_pkg::ADC_MAX)) begin
			mv_c = est_s3 + bga_pkg::MV_W'(2);
		end else if (rem_s3 >= bga_pkg::REM_W'(bga_pkg::ADC_MAX)) begin
			mv_c = est_s3 + bga_pkg::MV_W'(1);
		end else begin
			mv_c = est_s3;
		end
	end

	// segment whose lower point is the first one at or below mv
	always_comb begin
		seg_c = '0;
		for (int i = bga_pkg::CURVE_POINTS - 2; i >= 0; i--) begin
			if (mv_s4 >= bga_pkg::CURVE_MV[i+1]) seg_c = bga_pkg::SEG_W'(i);
		end
	end

	// interpolation: count step boundaries passed inside the segment
	always_comb begin
		lo_mv    = bga_pkg::CURVE_MV[seg_s5 + bga_pkg::SEG_W'(1)];
		width_mv = bga_pkg::CURVE_MV[seg_s5] - lo_mv;
		width    = width_mv[bga_pkg::DIFF_W-1:0];
		diff     = bga_pkg::DIFF_W'(mv_s5 - lo_mv);
		diff5    = bga_pkg::DIFF5_W'(diff) * bga_pkg::DIFF5_W'(bga_pkg::PCT_STEP);
		off      = '0;
		for (int k = 1; k < bga_pkg::PCT_STEP; k++) begin
			if (diff5 >= bga_pkg::DIFF5_W'(k) * bga_pkg::DIFF5_W'(width)) off = off + 1'b1;
		end
		if (top_s5) begin
			pct_c = bga_pkg::PCT_MAX;
		end else if (bot_s5) begin
			pct_c = '0;
		end else begin
			pct_c = bga_pkg::CURVE_PCT[seg_s5 + bga_pkg::SEG_W'(1)] + bga_pkg::PCT_W'(off);
		end
	end

	always_comb begin
		if (pin_s6) begin
			state_c = bga_pkg::CS_DISCHARGING;
		end else if (pct_s6 >= cfg.full_pct_threshold) begin
			state_c = bga_pkg::CS_FULL;
		end else begin
			state_c = bga_pkg::CS_CHARGING;
		end
		if (!pin_s6)                             level_c = bga_pkg::LVL_CHARGING;
		else if (pct_s6 < bga_pkg::PCT_LOW_LIM)  level_c = bga_pkg::LVL_LOW;
		else if (pct_s6 < bga_pkg::PCT_MID_LIM)  level_c = bga_pkg::LVL_MID;
		else if (pct_s6 < bga_pkg::PCT_HIGH_LIM) level_c = bga_pkg::LVL_HIGH;
		else                                     level_c = bga_pkg::LVL_FULL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_q  <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= bga_pkg::PROD_W'(in_data.avg) * bga_pkg::PROD_W'(cfg.full_scale_mv);
			pin_s1  <= in_data.pin;
			prod_s2 <= prod_s1;
			pin_s2  <= pin_s1;
			est_s2  <= est_sum[bga_pkg::PROD_W-1:12];
			est_s3  <= est_s2;
			rem_s3  <= rem_full[bga_pkg::REM_W-1:0];
			pin_s3  <= pin_s2;
			mv_s4   <= mv_c;
			pin_s4  <= pin_s3;
			mv_s5   <= mv_s4;
			seg_s5  <= seg_c;
			top_s5  <= (mv_s4 >= bga_pkg::MV_TOP);
			bot_s5  <= (mv_s4 <= bga_pkg::MV_BOT);
			pin_s5  <= pin_s4;
			mv_s6   <= mv_s5;
			pct_s6  <= pct_c;
			pin_s6  <= pin_s5;
			res_q.battery_mv   <= mv_s6;
			res_q.charge_pct   <= pct_s6;
			res_q.charge_state <= state_c;
			res_q.gauge_level  <= level_c;
		end
	end

endmodule
`default_nettype wire

@@ rtl/battery_gauge_averager_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_gauge_averager_top
// Averages ADC battery samples per block and reports millivolts, state of
// charge, charge state and gauge level.
// ----------------------------------------------------------------------------
// Use:
//   s_* carries one ADC sample per item with the charger pin level. Every
//   eighth item closes a block and yields one result item on m_*; the other
//   items yield nothing.
//   Path: the result of a block passes from the edge that takes its last
//   sample through queue, multiply, two divide steps, correction, segment
//   search, interpolation and the output register.
//   Throughput: one item per cycle while s_tready is high; the front only
//   accumulates, the back pipeline one block reading per cycle unless stalled.
//   Stall: a held m_tready freezes the back pipeline; the two-entry queue
//   absorbs block readings, and s_tready drops only when it is full.
//   Reset: sample sum and count clear, queue and pipeline empty, registers
//   return to 7800 mV full scale and a 99 % full threshold.
//   Config: cfg_we writes register cfg_index (0 full scale mV, 1 full
//   threshold %) from cfg_data; write only while the block is idle.
// ----------------------------------------------------------------------------
module battery_gauge_averager_top (
	input  wire                      clk,
	input  wire                      arst_n,
	// sample in
	input  wire                      s_tvalid,
	output logic                     s_tready,
	input  wire [15:0]               s_tdata,   // raw_sample[11:0], charger_pin[12], zero
	// result out
	output logic                     m_tvalid,
	input  wire                      m_tready,
	output logic [31:0]              m_tdata,   // battery_mv[13:0], charge_pct[20:14],
	                                            // charge_state[22:21], gauge_level[25:23]
	// configuration
	input  wire                      cfg_we,
	input  wire [bga_pkg::IDX_W-1:0] cfg_index,
	input  wire [bga_pkg::MV_W-1:0]  cfg_data
);

	logic [bga_pkg::MV_W-1:0]  full_scale_q;
	logic [bga_pkg::THR_W-1:0] full_thr_q;
	bga_pkg::bga_cfg_t         cfg;

	logic                      take;
	logic                      push;
	bga_pkg::bga_reading_t     push_data;
	bga_pkg::bga_reading_t     pop_data;
	bga_pkg::bga_qstat_t       qstat;
	logic                      pop;
	bga_pkg::bga_result_t      result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= bga_pkg::FULL_SCALE_RST;
			full_thr_q   <= bga_pkg::FULL_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bga_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data;
				bga_pkg::REG_FULL_THR:   full_thr_q   <= cfg_data[bga_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.full_scale_mv      = full_scale_q;
	assign cfg.full_pct_threshold = full_thr_q;

	// input is held off only while the queue is full
	assign s_tready = !qstat.full;
	assign take     = s_tvalid && s_tready;

	bga_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.raw_sample  (s_tdata[bga_pkg::RAW_W-1:0]),
		.charger_pin (s_tdata[bga_pkg::RAW_W]),
		.push        (push),
		.push_data   (push_data)
	);

	bga_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	bga_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (!qstat.empty),
		.in_data   (pop_data),
		.in_pop    (pop),
		.out_valid (m_tvalid),
		.out_data  (result),
		.out_ready (m_tready)
	);

	assign m_tdata = {6'd0, result};

	// a discharging result always carries a non-zero gauge level, others zero
	a_level_vs_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((result.charge_state == bga_pkg::CS_DISCHARGING) ==
		              (result.gauge_level != bga_pkg::LVL_CHARGING)))
		else $error("gauge level disagrees with charge state");

	// percent never exceeds 100
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result.charge_pct <= bga_pkg::PCT_MAX))
		else $error("charge percent out of range");

	// full is reported only at or above the threshold
	a_full_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (result.charge_state == bga_pkg::CS_FULL)) |->
		(result.charge_pct >= full_thr_q))
		else $error("full reported below threshold");

	// the queue never takes a reading while full: the front is held off first
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push)
		else $error("block reading pushed into a full queue");

endmodule
`default_nettype wire

@@ tb/tb_battery_gauge_averager_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_gauge_averager_top
// Drives blocks of ADC samples into the gauge averager and compares every
// reading with a local model: block average, millivolts, percentage from the
// discharge curve, charge state and icon level. Both handshakes are stalled at
// random and the register settings are swept between phases.
// ----------------------------------------------------------------------------
module tb_battery_gauge_averager_top;
	import bga_pkg::*;

	localparam int CURVE_N = 21;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;    // raw_sample[11:0], charger_pin[12], zero
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;    // battery_mv[13:0], charge_pct[20:14],
	                                   // charge_state[22:21], gauge_level[25:23]
	logic                  cfg_we;
	logic [IDX_W-1:0]      cfg_index;
	logic [MV_W-1:0]       cfg_data;

	// discharge curve, top point first
	int curve_mv_pts [CURVE_N] = '{
		4200, 4150, 4100, 4050, 4000, 3950, 3900, 3850, 3800, 3750, 3700,
		3650, 3600, 3550, 3500, 3450, 3400, 3350, 3300, 3200, 3000
	};
	int curve_pct_pts [CURVE_N] = '{
		100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
		45, 40, 35, 30, 25, 20, 15, 10, 5, 0
	};

	// model state, mirrors what the block holds
	logic [MV_W-1:0]  model_full_scale;
	logic [THR_W-1:0] model_full_thr;
	logic [15:0]      acc_sum;
	int               acc_count;
	bga_result_t      expected_readings [$];

	int  errors;
	int  samples_taken;
	int  readings_checked;
	int  tready_hold;   // receiver hold-off, counted down by the receiver
	bit  no_idle;       // both sides run flat out while set

	battery_gauge_averager_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// percentage on the discharge curve, linear within each 5 % segment
	function automatic logic [PCT_W-1:0] pct_from_mv(input logic [MV_W-1:0] mv);
		int k;
		int pct;
		bit found;
		pct = 0;
		found = 1'b0;
		if (mv >= 4200)
			pct = 100;
		else if (mv > 3000) begin
			for (k = 0; k + 1 < CURVE_N; k++) begin
				if (!found && mv >= curve_mv_pts[k+1]) begin
					found = 1'b1;
					pct = curve_pct_pts[k+1]
						+ ((int'(mv) - curve_mv_pts[k+1])
						* (curve_pct_pts[k] - curve_pct_pts[k+1]))
						/ (curve_mv_pts[k] - curve_mv_pts[k+1]);
				end
			end
		end
		return PCT_W'(pct);
	endfunction

	// one reading from a finished block sum and the pin level of its last item
	function automatic bga_result_t predict_reading(input logic [15:0] sum, input logic pin);
		bga_result_t r;
		logic [RAW_W-1:0] avg;
		logic [25:0] prod;
		avg = RAW_W'(sum / SAMPLES_PER_READING);
		prod = 26'(avg) * 26'(model_full_scale);
		r.battery_mv = MV_W'(prod / ADC_MAX);
		r.charge_pct = pct_from_mv(r.battery_mv);
		if (pin)
			r.charge_state = CS_DISCHARGING;
		else if (r.charge_pct >= model_full_thr)
			r.charge_state = CS_FULL;
		else
			r.charge_state = CS_CHARGING;
		if (r.charge_state != CS_DISCHARGING)
			r.gauge_level = LVL_CHARGING;
		else if (r.charge_pct < PCT_LOW_LIM)
			r.gauge_level = LVL_LOW;
		else if (r.charge_pct < PCT_MID_LIM)
			r.gauge_level = LVL_MID;
		else if (r.charge_pct < PCT_HIGH_LIM)
			r.gauge_level = LVL_HIGH;
		else
			r.gauge_level = LVL_FULL;
		return r;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Sampling at the rising edge: register writes, accepted samples feed the
	// model, accepted readings are checked against the oldest prediction.
	always @(posedge clk) begin : monitor
		bga_result_t got;
		bga_result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_FULL_SCALE)
					model_full_scale = cfg_data;
				else if (cfg_index == REG_FULL_THR)
					model_full_thr = cfg_data[THR_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				acc_sum = acc_sum + s_tdata[RAW_W-1:0];
				acc_count++;
				samples_taken++;
				if (acc_count == SAMPLES_PER_READING) begin
					expected_readings.push_back(predict_reading(acc_sum, s_tdata[12]));
					acc_sum = '0;
					acc_count = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				got = bga_result_t'(m_tdata[25:0]);
				if (expected_readings.size() == 0) begin
					errors++;
					$display("%0t: unexpected reading, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want = expected_readings.pop_front();
					check_field("battery_mv", int'(want.battery_mv), int'(got.battery_mv));
					check_field("charge_pct", int'(want.charge_pct), int'(got.charge_pct));
					check_field("charge_state", int'(want.charge_state),
						int'(got.charge_state));
					check_field("gauge_level", int'(want.gauge_level),
						int'(got.gauge_level));
					readings_checked++;
				end
			end
		end
	end

	// Receiver: random stalls, a counted hold-off on request, none while no_idle.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (tready_hold > 0) begin
				m_tready = 1'b0;
				tready_hold--;
			end else if (no_idle)
				m_tready = 1'b1;
			else
				m_tready = ($urandom_range(99) >= 15);
		end
	end

	// Offers one item from the falling edge and returns at the edge that takes
	// it; tvalid stays high into the next call unless an idle gap is drawn.
	task automatic send_sample(input logic [RAW_W-1:0] raw, input logic pin);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 15) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {3'b000, pin, raw};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// sender quiet, every reading in, then a further wait for the pipeline to drain
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MV_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// A block aimed at a chosen voltage under the current full scale, with a
	// little spread between samples; only the last item's pin level counts.
	task automatic send_block(input int mv_aim, input int spread, input logic pin);
		int target;
		int raw;
		int k;
		if (model_full_scale == 0)
			target = $urandom_range(4095);
		else
			target = (mv_aim * ADC_MAX) / model_full_scale;
		if (target > 4095)
			target = 4095;
		for (k = 0; k < SAMPLES_PER_READING; k++) begin
			raw = target + $urandom_range(2 * spread) - spread;
			if (raw < 0)
				raw = 0;
			else if (raw > 4095)
				raw = 4095;
			send_sample(RAW_W'(raw), (k == SAMPLES_PER_READING - 1) ? pin : 1'($urandom));
		end
	endtask

	// Field extremes, pin taken from the last item only, and average flooring.
	task automatic test_directed();
		int k;
		for (k = 0; k < SAMPLES_PER_READING; k++)
			send_sample('0, 1'b1);
		for (k = 0; k < SAMPLES_PER_READING; k++)
			send_sample('1, 1'b0);
		// sum not a multiple of eight; pin low except on the closing item
		for (k = 0; k < SAMPLES_PER_READING; k++)
			send_sample((k == 0) ? 12'd4095 : RAW_W'(1700 + k),
				(k == SAMPLES_PER_READING - 1));
	endtask

	// Settings from the extremes inward, including thresholds above 100 and zero.
	task automatic test_setting_sweep();
		int fs_set [7] = '{7800, 16383, 0, 4095, 5200, 9000, 7800};
		int thr_set [7] = '{99, 100, 0, 127, 50, 80, 1};
		int p;
		int b;
		for (p = 0; p < 7; p++) begin
			write_reg(REG_FULL_SCALE, MV_W'(fs_set[p]));
			write_reg(REG_FULL_THR, MV_W'(thr_set[p]));
			no_idle = (p == 4);
			for (b = 0; b < 25; b++) begin
				if ($urandom_range(7) == 0)
					send_block($urandom_range(16383), $urandom_range(200), 1'($urandom));
				else
					send_block($urandom_range(2900, 4300), $urandom_range(40),
						1'($urandom));
			end
			no_idle = 1'b0;
		end
	endtask

	// A write between samples of one block: the partial sum must survive and
	// the new scale applies to that block.
	task automatic test_midblock_write();
		int k;
		wait_idle();
		for (k = 0; k < 3; k++)
			send_sample(RAW_W'($urandom_range(1500, 2300)), 1'($urandom));
		write_reg(REG_FULL_SCALE, MV_W'(6600));
		for (k = 3; k < SAMPLES_PER_READING; k++)
			send_sample(RAW_W'($urandom_range(1500, 2300)), 1'($urandom));
	endtask

	// Receiver holds off long enough for the queue to fill and s_tready to drop.
	task automatic test_backpressure();
		int b;
		wait_idle();
		tready_hold = 300;
		for (b = 0; b < 12; b++)
			send_block($urandom_range(3000, 4200), $urandom_range(20), 1'($urandom));
	endtask

	// Unshaped samples and pin levels from random bit patterns.
	task automatic test_noise();
		int k;
		for (k = 0; k < 40 * SAMPLES_PER_READING; k++)
			send_sample(RAW_W'($urandom), 1'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FULL_SCALE;
		cfg_data = '0;
		model_full_scale = FULL_SCALE_RST;
		model_full_thr = FULL_THR_RST;
		acc_sum = '0;
		acc_count = 0;
		errors = 0;
		samples_taken = 0;
		readings_checked = 0;
		tready_hold = 0;
		no_idle = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_setting_sweep();
		test_midblock_write();
		test_backpressure();
		test_noise();
		wait_idle();

		$display("Sent %0d samples and checked %0d readings over seven register settings,",
			samples_taken, readings_checked);
		$display("a mid-block write, a long receiver hold-off and unshaped samples.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Timeout waiting for the block");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
